// ----- src/scgd_pkg.sv -----
// Shared types and constants of the sparse count-gradient dot product block.
// Used by the front, the job queue, the divider and the top level.
package scgd_pkg;

  localparam int GRAD_DEPTH = 1024;
  localparam int GRAD_AW    = $clog2(GRAD_DEPTH);
  localparam int GRAD_W     = 32;
  localparam int LEN_W      = 11;
  localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam int SUM_W  = 64;
  localparam int DIV_CW = $clog2(SUM_W);

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_ACCUM = 2'd1,
    ACT_CLOSE = 2'd2
  } action_e;

  // one closed circuit waiting for its division
  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [31:0]             shots;
    logic                    err;
  } job_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_CALC = 2'b10
  } div_state_e;

endpackage

// ----- src/scgd_if.sv -----
// Request and response channel interfaces (valid/ready handshake).
// Standalone; field widths follow the block's item definition.
interface scgd_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [9:0]         gradient_slot;
  logic signed [31:0] gradient_value;
  logic [31:0]        outcome_index;
  logic [31:0]        outcome_count;
  logic [31:0]        shot_total;
  logic               last_in_circuit;

  modport source (output valid, action, gradient_slot, gradient_value, outcome_index,
                  outcome_count, shot_total, last_in_circuit, input ready);
  modport sink   (input valid, action, gradient_slot, gradient_value, outcome_index,
                  outcome_count, shot_total, last_in_circuit, output ready);
endinterface

interface scgd_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] circuit_value;
  logic               status;

  modport source (output valid, circuit_value, status, input ready);
  modport sink   (input valid, circuit_value, status, output ready);
endinterface

// ----- src/sparse_count_gradient_dot_core.sv -----
// Sparse count-gradient dot product core: top level.
// Depends on scgd_pkg, scgd_if, scgd_front, scgd_fifo and scgd_back.
//
// Use:
//   Requests arrive on req_i (valid/ready). Action 0 writes a Q16.16 gradient
//   entry into the 1024-entry store; action 1 adds count * gradient[index] into
//   a saturating 64-bit sum (an index at or above gradient_length only marks
//   an error); action 1 with last_in_circuit, or action 2, closes the circuit.
//   Each close yields one response on rsp_o: sum / shot_total, truncated and
//   saturated to 32 bits, status 1 on a range error, zero for zero shots.
//   gradient_length is written through cfg_we_i/cfg_wdata_i while idle.
// Throughput: the front takes one request per cycle while req_i.ready is
//   high (store read, 32x32 multiply and accumulate are pipelined over three
//   stages). A close goes into a 4-deep job queue; the divider retires one
//   bit per cycle unless a held response stops its last step; a zero-shot or
//   error close skips the division. Queued jobs and a held response delay results.
// Reset: sum, error flag, queue and divider clear; gradient_length returns to
//   1024; the gradient store is not cleared and must be written before use.
// Stall: a held response stops the divider; once the queue cannot take the
//   closes in flight, req_i.ready drops until room frees up.
module sparse_count_gradient_dot_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [scgd_pkg::LEN_W-1:0]  cfg_wdata_i,
  scgd_req_if.sink                    req_i,
  scgd_rsp_if.source                  rsp_o
);
  import scgd_pkg::*;

  logic               push, pop, empty;
  job_t               push_job, head_job;
  logic [FIFO_CW-1:0] fifo_count;

  // front end: store, multiply, accumulate
  scgd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .req          (req_i),
    .fifo_count_i (fifo_count),
    .push_o       (push),
    .job_o        (push_job)
  );

  // decoupling queue of closed circuits
  scgd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .job_o   (head_job),
    .empty_o (empty),
    .count_o (fifo_count)
  );

  // back end: divide, saturate, present result
  scgd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .job_i   (head_job),
    .pop_o   (pop),
    .rsp     (rsp_o)
  );

  a_ready_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready |-> fifo_count < FIFO_CW'(FIFO_DEPTH))
    else $error("request taken with no room for its close");

endmodule

// ----- src/scgd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module scgd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- src/scgd_fifo.sv -----
// Short queue of closed-circuit jobs between the front and the divider.
// Depends on scgd_pkg.
module scgd_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  scgd_pkg::job_t                job_i,
  input  logic                          pop_i,
  output scgd_pkg::job_t                job_o,
  output logic                          empty_o,
  output logic [scgd_pkg::FIFO_CW-1:0]  count_o
);
  import scgd_pkg::*;

  job_t               mem_q [FIFO_DEPTH];
  logic [FIFO_PW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [FIFO_CW-1:0] cnt_q, cnt_d;

  function automatic logic [FIFO_PW-1:0] ptr_inc(input logic [FIFO_PW-1:0] p);
    return (p == FIFO_PW'(FIFO_DEPTH - 1)) ? '0 : p + FIFO_PW'(1);
  endfunction

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + FIFO_CW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - FIFO_CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  assign job_o   = mem_q[rd_ptr_q];
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0) else $error("job queue popped while empty");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q != FIFO_CW'(FIFO_DEPTH)) || pop_i)
    else $error("job queue pushed while full");

endmodule

// ----- src/scgd_front.sv -----
// Front: takes requests, writes the gradient store, multiplies and accumulates.
// Depends on scgd_pkg, scgd_if and scgd_ram; pushes closed circuits to the job queue.
module scgd_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [scgd_pkg::LEN_W-1:0]       cfg_wdata_i,
  scgd_req_if.sink                         req,
  input  logic [scgd_pkg::FIFO_CW-1:0]     fifo_count_i,
  output logic                             push_o,
  output scgd_pkg::job_t                   job_o
);
  import scgd_pkg::*;

  logic [LEN_W-1:0] len_q;

  // stage 0 decode
  action_e             act;
  logic                accept;
  logic                s0_write, s0_accum, s0_close, s0_err, s0_hit;
  logic [31:0]         lim, slot_ext;
  logic [GRAD_AW-1:0]  waddr, raddr;
  logic [GRAD_W-1:0]   rdata;

  // stage 1: store read data present
  logic        s1_acc_q, s1_err_q, s1_close_q;
  logic [31:0] s1_cnt_q, s1_shots_q;
  logic        g_neg;
  logic [31:0] g_mag;

  // stage 2: product present
  logic             s2_acc_q, s2_err_q, s2_close_q, s2_neg_q;
  logic [SUM_W-1:0] s2_mag_q;
  logic [31:0]      s2_shots_q;

  logic signed [SUM_W-1:0] sum_q, sum_d, addend, raw, sum_add;
  logic                    err_q, err_d, err_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LEN_RESET;
    end else if (cfg_we_i) begin
      len_q <= cfg_wdata_i;
    end
  end

  // room must remain for every close already in the pipe
  assign req.ready = (32'(fifo_count_i) + 32'(s1_close_q) + 32'(s2_close_q))
                     < 32'(FIFO_DEPTH);
  assign accept    = req.valid && req.ready;

  always_comb begin
    act      = action_e'(req.action);
    lim      = (32'(len_q) > 32'(GRAD_DEPTH)) ? 32'(GRAD_DEPTH) : 32'(len_q);
    slot_ext = 32'(req.gradient_slot);
    waddr    = slot_ext[GRAD_AW-1:0];
    raddr    = req.outcome_index[GRAD_AW-1:0];
    s0_hit   = req.outcome_index < lim;
    s0_write = 1'b0;
    s0_accum = 1'b0;
    s0_close = 1'b0;
    s0_err   = 1'b0;
    if (accept) begin
      unique case (act)
        ACT_WRITE: s0_write = slot_ext < 32'(GRAD_DEPTH);
        ACT_ACCUM: begin
          s0_accum = s0_hit;
          s0_err   = !s0_hit;
          s0_close = req.last_in_circuit;
        end
        ACT_CLOSE: s0_close = 1'b1;
        default: ;
      endcase
    end
  end

  scgd_ram #(.WIDTH(GRAD_W), .DEPTH(GRAD_DEPTH)) u_store (
    .clk_i   (clk_i),
    .we_i    (s0_write),
    .waddr_i (waddr),
    .wdata_i (req.gradient_value),
    .re_i    (s0_accum),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    g_neg = rdata[GRAD_W-1];
    g_mag = g_neg ? (~rdata + 32'd1) : rdata;
  end

  always_comb begin
    addend  = s2_neg_q ? -$signed(s2_mag_q) : $signed(s2_mag_q);
    raw     = sum_q + addend;
    sum_add = sum_q;
    if (s2_acc_q) begin
      if ((sum_q[SUM_W-1] == addend[SUM_W-1]) && (raw[SUM_W-1] != sum_q[SUM_W-1])) begin
        sum_add = sum_q[SUM_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
        sum_add = raw;
      end
    end
    err_new = err_q | s2_err_q;
    sum_d   = s2_close_q ? '0 : sum_add;
    err_d   = s2_close_q ? 1'b0 : err_new;
  end

  assign push_o      = s2_close_q;
  assign job_o.sum   = sum_add;
  assign job_o.shots = s2_shots_q;
  assign job_o.err   = err_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_acc_q   <= 1'b0;
      s1_err_q   <= 1'b0;
      s1_close_q <= 1'b0;
      s2_acc_q   <= 1'b0;
      s2_err_q   <= 1'b0;
      s2_close_q <= 1'b0;
      sum_q      <= '0;
      err_q      <= 1'b0;
    end else begin
      s1_acc_q   <= s0_accum;
      s1_err_q   <= s0_err;
      s1_close_q <= s0_close;
      s2_acc_q   <= s1_acc_q;
      s2_err_q   <= s1_err_q;
      s2_close_q <= s1_close_q;
      sum_q      <= sum_d;
      err_q      <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_cnt_q   <= req.outcome_count;
    s1_shots_q <= req.shot_total;
    s2_neg_q   <= g_neg;
    s2_mag_q   <= SUM_W'(g_mag) * SUM_W'(s1_cnt_q);
    s2_shots_q <= s1_shots_q;
  end

endmodule

// ----- src/scgd_back.sv -----
// Back: restoring 64/32 divider, one quotient bit per cycle unless stalled, saturation
// and result register. Depends on scgd_pkg and scgd_if; pops jobs from the job queue.
module scgd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  scgd_pkg::job_t  job_i,
  output logic            pop_o,
  scgd_rsp_if.source      rsp
);
  import scgd_pkg::*;

  div_state_e        state_q, state_d;
  logic [DIV_CW-1:0] cnt_q, cnt_d;
  logic [SUM_W-1:0]  quo_q, quo_d, mag;
  logic [32:0]       rem_q, rem_d, trial;
  logic [31:0]       den_q, den_d;
  logic              neg_q, neg_d;
  logic              out_v_q, out_v_d, out_free, out_we, last_step, step;
  logic [31:0]       val_d, val_q;
  logic              st_d, st_q;
  logic [SUM_W-1:0]  q_fin;

  assign out_free  = !out_v_q || rsp.ready;
  assign last_step = (cnt_q == DIV_CW'(SUM_W - 1));

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    den_d   = den_q;
    neg_d   = neg_q;
    pop_o   = 1'b0;
    out_we  = 1'b0;
    val_d   = val_q;
    st_d    = st_q;
    step    = 1'b0;
    mag     = job_i.sum[SUM_W-1] ? (~job_i.sum + SUM_W'(1)) : job_i.sum;
    trial   = {rem_q[31:0], quo_q[SUM_W-1]};
    q_fin   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i && out_free) begin
          pop_o = 1'b1;
          if (job_i.shots == '0) begin
            out_we = 1'b1;
            val_d  = '0;
            st_d   = 1'b0;
          end else if (job_i.err) begin
            out_we = 1'b1;
            val_d  = '0;
            st_d   = 1'b1;
          end else begin
            neg_d   = job_i.sum[SUM_W-1];
            quo_d   = mag;
            rem_d   = '0;
            den_d   = job_i.shots;
            cnt_d   = '0;
            state_d = ST_CALC;
          end
        end
      end
      ST_CALC: begin
        step = !last_step || out_free;
        if (step) begin
          if (trial >= {1'b0, den_q}) begin
            rem_d = trial - {1'b0, den_q};
            quo_d = {quo_q[SUM_W-2:0], 1'b1};
          end else begin
            rem_d = trial;
            quo_d = {quo_q[SUM_W-2:0], 1'b0};
          end
          cnt_d = cnt_q + DIV_CW'(1);
          if (last_step) begin
            q_fin  = quo_d;
            out_we = 1'b1;
            st_d   = 1'b0;
            if (neg_q) begin
              if ((|q_fin[SUM_W-1:32]) || (q_fin[31] && (|q_fin[30:0]))) begin
                val_d = 32'h8000_0000;
              end else begin
                val_d = ~q_fin[31:0] + 32'd1;
              end
            end else begin
              val_d = (|q_fin[SUM_W-1:31]) ? 32'h7FFF_FFFF : q_fin[31:0];
            end
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
    out_v_d = out_we ? 1'b1 : (rsp.ready ? 1'b0 : out_v_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
    val_q <= val_d;
    st_q  <= st_d;
  end

  assign rsp.valid         = out_v_q;
  assign rsp.circuit_value = val_q;
  assign rsp.status        = st_q;

  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CALC |-> den_q != '0) else $error("divider running on zero shots");

  a_finish_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CALC && last_step && step) |=> (out_v_q && state_q == ST_IDLE))
    else $error("finished division did not reach the result register");

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for sparse_count_gradient_dot_core: gradient loads,
// outcome accumulation and circuit closes, predicted per request and checked in order.
// Depends on scgd_pkg, scgd_if and the core RTL.
module testbench;
  import scgd_pkg::*;

  localparam int unsigned CLK_PERIOD      = 8;
  localparam int unsigned WATCHDOG_CYCLES = 4_000_000;
  // covers the divider, the job queue and the front pipe after the last result
  localparam int unsigned SETTLE_CYCLES   = 100;
  localparam int unsigned PHASES          = 11;
  localparam int unsigned PHASE_ITEMS     = 150;
  localparam int unsigned DIR_ROWS        = 25;

  // action code the block leaves unused; it must be dropped silently
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef struct packed {
    logic [1:0]         action;
    logic [9:0]         slot;
    logic signed [31:0] value;
    logic [31:0]        index;
    logic [31:0]        count;
    logic [31:0]        shots;
    logic               last;
  } req_item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               status;
  } rsp_item_t;

  typedef struct packed {
    req_item_t req;
    logic      typed;  // 1: want holds the expected result, else the predictor decides
    rsp_item_t want;
  } dir_row_t;

  // Directed requests. Slots 0, 1023, 1, 2 get max, min, +1.0 and -1.0.
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // close straight after reset: accumulator is zero
    '{'{ACT_CLOSE,  10'd0,    32'sd0,           32'd0,    32'd0,       32'd5,       1'b0},
      1'b1, '{32'sd0, 1'b0}},
    '{'{ACT_WRITE,  10'd0,    32'sh7FFF_FFFF,   32'd0,    32'd0,       32'd0,       1'b0},
      1'b0, '{32'sd0, 1'b0}},
    '{'{ACT_WRITE,  10'd1023, 32'sh8000_0000,   32'd0,    32'd0,       32'd0,       1'b0},
      1'b0, '{32'sd0, 1'b0}},
    '{'{ACT_WRITE,  10'd1,    32'sh0001_0000,   32'd0,    32'd0,       32'd0,       1'b0},
      1'b0, '{32'sd0, 1'b0}},
    '{'{ACT_WRITE,  10'd2,    32'shFFFF_0000,   32'd0,    32'd0,       32'd0,       1'b0},
      1'b0, '{32'sd0, 1'b0}},
    // 3 * 1.0 - 1.0, over two shots
    '{'{ACT_ACCUM,  10'd0,    32'sd0,           32'd1,    32'd3,       32'd0,       1'b0},
      1'b0, '{32'sd0, 1'b0}},
    '{'{ACT_ACCUM,  10'd0,    32'sd0,           32'd2,    32'd1,       32'd2,       1'b1},
      1'b0, '{32'sd0, 1'b0}},
    // two max products push the sum past the positive limit
    '{'{ACT_ACCUM,  10'd0,    32'sd0,           32'd0,    32'hFFFF_FFFF, 32'd0,     1'b0},
      1'b0, '{32'sd0, 1'b0}},
    '{'{ACT_ACCUM,  10'd0,    32'sd0,           32'd0,    32'hFFFF_FFFF, 32'd0,     1'b0},
      1'b0, '{32'sd0, 1'b0}},
    '{'{ACT_ACCUM,  10'd0,    32'sd0,           32'd0,    32'd1,       32'd1,       1'b1},
      1'b1, '{32'sh7FFF_FFFF, 1'b0}},
    // same on the negative side, quotient clamps to the most negative value
    '{'{ACT_ACCUM,  10'd0,    32'sd0,           32'd1023, 32'hFFFF_FFFF, 32'd0,     1'b0},
      1'b0, '{32'sd0, 1'b0}},
    '{'{ACT_ACCUM,  10'd0,    32'sd0,           32'd1023, 32'hFFFF_FFFF, 32'd0,     1'b0},
      1'b0, '{32'sd0, 1'b0}},
    '{'{ACT_ACCUM,  10'd0,    32'sd0,           32'd1023, 32'd0,       32'hFFFF_FFFF, 1'b1},
      1'b1, '{32'sh8000_0000, 1'b0}},
    // index one past the end: error status, value zero
    '{'{ACT_ACCUM,  10'd0,    32'sd0,           32'd1024, 32'd5,       32'd0,       1'b0},
      1'b0, '{32'sd0, 1'b0}},
    '{'{ACT_ACCUM,  10'd0,    32'sd0,           32'd1,    32'd2,       32'd3,       1'b1},
      1'b1, '{32'sd0, 1'b1}},
    // zero shots wins over a range error
    '{'{ACT_ACCUM,  10'd0,    32'sd0,           32'hFFFF_FFFF, 32'd1,  32'd0,       1'b1},
      1'b1, '{32'sd0, 1'b0}},
    // unused action, all fields but the index high, no result
    '{'{ACT_UNUSED, 10'h3FF,  32'shFFFF_FFFF,   32'd1,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1},
      1'b0, '{32'sd0, 1'b0}},
    '{'{ACT_ACCUM,  10'd0,    32'sd0,           32'd2,    32'd7,       32'd0,       1'b0},
      1'b0, '{32'sd0, 1'b0}},
    '{'{ACT_ACCUM,  10'd0,    32'sd0,           32'd1,    32'd2,       32'd0,       1'b1},
      1'b1, '{32'sd0, 1'b0}},
    // empty close after a proper close
    '{'{ACT_CLOSE,  10'd0,    32'sd0,           32'd0,    32'd0,       32'hFFFF_FFFF, 1'b0},
      1'b1, '{32'sd0, 1'b0}},
    '{'{ACT_ACCUM,  10'd0,    32'sd0,           32'd2,    32'd3,       32'd7,       1'b1},
      1'b0, '{32'sd0, 1'b0}},
    // last flag on a write means nothing
    '{'{ACT_WRITE,  10'd3,    32'sd1,           32'd0,    32'd0,       32'd0,       1'b1},
      1'b0, '{32'sd0, 1'b0}},
    '{'{ACT_ACCUM,  10'd0,    32'sd0,           32'd3,    32'd1,       32'd0,       1'b0},
      1'b0, '{32'sd0, 1'b0}},
    // close with entries pending, 1/2 truncates to zero
    '{'{ACT_CLOSE,  10'd0,    32'sd0,           32'd0,    32'd0,       32'd2,       1'b0},
      1'b0, '{32'sd0, 1'b0}},
    // negative quotient truncates toward zero
    '{'{ACT_ACCUM,  10'd0,    32'sd0,           32'd1023, 32'd1,       32'd3,       1'b1},
      1'b0, '{32'sd0, 1'b0}}
  };

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [LEN_W-1:0] cfg_wdata_i;

  scgd_req_if req_if ();
  scgd_rsp_if rsp_if ();

  sparse_count_gradient_dot_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  always begin
    clk_i = 1'b0;
    #(CLK_PERIOD / 2);
    clk_i = 1'b1;
    #(CLK_PERIOD / 2);
  end

  // ---------------------------------------------------------------------------
  // Predictor state: own copy of the store, accumulator, error flag and length.
  // ---------------------------------------------------------------------------
  logic [31:0]             grad_mem [GRAD_DEPTH];
  logic signed [SUM_W-1:0] acc_sum;
  bit                      acc_range_err;
  logic [LEN_W-1:0]        len_reg;

  // stimulus bookkeeping: which store slots hold data, so no read hits an empty slot
  bit          slot_written [GRAD_DEPTH];
  int unsigned written_slots [$];

  rsp_item_t   pending_circuits [$];
  int unsigned mismatches;
  int unsigned circuits_seen;
  bit          steady;  // no idling on either side while set

  function automatic int unsigned active_length();
    return (len_reg > LEN_W'(GRAD_DEPTH)) ? GRAD_DEPTH : 32'(len_reg);
  endfunction

  // sum / shots, truncated toward zero and clamped to Q16.16 range
  function automatic rsp_item_t circuit_quotient(input logic [31:0] shots);
    rsp_item_t   res;
    logic [63:0] mag;
    logic [63:0] q;
    res = '0;
    if (shots == 0) begin
      res.value = 32'sd0;
    end else if (acc_range_err) begin
      res.status = 1'b1;
    end else begin
      mag = acc_sum[SUM_W-1] ? -acc_sum : acc_sum;
      q = mag / {32'd0, shots};
      if (acc_sum[SUM_W-1]) begin
        if (q > 64'h8000_0000) q = 64'h8000_0000;
        res.value = -q[31:0];
      end else begin
        if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
        res.value = q[31:0];
      end
    end
    return res;
  endfunction

  // one accepted request: update state, report whether it closes a circuit
  function automatic void dot_step(input req_item_t it, output bit yields,
                                   output rsp_item_t res);
    logic [31:0]             g;
    logic signed [SUM_W-1:0] prod;
    logic signed [SUM_W-1:0] total;
    bit                      closing;
    yields  = 1'b0;
    res     = '0;
    closing = 1'b0;
    case (it.action)
      ACT_WRITE: begin
        grad_mem[it.slot] = it.value;
      end
      ACT_ACCUM: begin
        if (it.index >= active_length()) begin
          acc_range_err = 1'b1;
        end else begin
          g = grad_mem[it.index];
          // |g * count| < 2^63, so the wrapped 64-bit product is exact
          prod  = {{32{g[31]}}, g} * {32'd0, it.count};
          total = acc_sum + prod;
          if (acc_sum[SUM_W-1] == prod[SUM_W-1] && total[SUM_W-1] != acc_sum[SUM_W-1]) begin
            total = acc_sum[SUM_W-1] ? SUM_MIN : SUM_MAX;
          end
          acc_sum = total;
        end
        closing = it.last;
      end
      ACT_CLOSE: begin
        closing = 1'b1;
      end
      default: ;
    endcase
    if (closing) begin
      yields        = 1'b1;
      res           = circuit_quotient(it.shots);
      acc_sum       = '0;
      acc_range_err = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 150);
  endfunction

  function automatic logic [31:0] pick_value();
    int v;
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3, 4, 5: return $urandom;
      default: begin
        v = $urandom_range(0, 32'h20_0000);
        return v - 32'h10_0000;
      end
    endcase
  endfunction

  function automatic logic [31:0] pick_count();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2, 3, 4: return $urandom;
      5: return $urandom_range(0, 65535);
      default: return $urandom_range(1, 1000);
    endcase
  endfunction

  function automatic logic [31:0] pick_shots();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'hFFFF_FFFF;
      3, 4: return $urandom;
      default: return $urandom_range(2, 1000);
    endcase
  endfunction

  // index at or above the active length
  function automatic logic [31:0] wild_index();
    int unsigned lim;
    lim = active_length();
    case ($urandom_range(0, 3))
      0: return lim;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(lim, lim + 64);
      default: return $urandom_range(lim, 32'hFFFF_FFFF);
    endcase
  endfunction

  // in-range index of a written slot, else falls back to an error index
  function automatic logic [31:0] grad_index();
    int unsigned lim;
    int unsigned s;
    lim = active_length();
    if (lim > 0) begin
      for (int k = 0; k < 8; k++) begin
        s = $urandom_range(0, lim - 1);
        if (slot_written[s]) return s;
      end
      for (int k = 0; k < 8; k++) begin
        s = written_slots[$urandom_range(0, written_slots.size() - 1)];
        if (s < lim) return s;
      end
    end
    return wild_index();
  endfunction

  function automatic void note_written(input int unsigned slot);
    if (!slot_written[slot]) begin
      slot_written[slot] = 1'b1;
      written_slots.push_back(slot);
    end
  endfunction

  function automatic req_item_t rand_item();
    req_item_t it;
    it.action = 2'($urandom_range(0, 3));
    it.slot   = 10'($urandom);
    it.value  = $urandom;
    it.index  = $urandom;
    it.count  = $urandom;
    it.shots  = $urandom;
    it.last   = 1'($urandom);
    return it;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at result %0d: %s got %h want %h", circuits_seen, what, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: optional idle gap, then hold the request until accepted.
  // The expectation is formed at the accepting edge.
  // ---------------------------------------------------------------------------
  task automatic send_req(input req_item_t it, input bit typed = 1'b0,
                          input rsp_item_t want = '0);
    int unsigned gap;
    bit          yields;
    rsp_item_t   res;
    gap = 0;
    if (!steady && $urandom_range(0, 99) < 40) gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid           <= 1'b1;
    req_if.action          <= it.action;
    req_if.gradient_slot   <= it.slot;
    req_if.gradient_value  <= it.value;
    req_if.outcome_index   <= it.index;
    req_if.outcome_count   <= it.count;
    req_if.shot_total      <= it.shots;
    req_if.last_in_circuit <= it.last;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    dot_step(it, yields, res);
    if (yields) pending_circuits.push_back(typed ? want : res);
  endtask

  // drop valid, let every pending result arrive, then let the pipe empty
  task automatic wait_idle();
    req_if.valid <= 1'b0;
    while (pending_circuits.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_length(input logic [LEN_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    len_reg      = v;
  endtask

  // ---------------------------------------------------------------------------
  // Response side: random back-pressure, in-order check against the predictor.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned stall;
    rsp_item_t   want;
    rsp_if.ready = 1'b0;
    stall        = 0;
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready) begin
        if (pending_circuits.size() == 0) begin
          report_mismatch("result with none pending", rsp_if.circuit_value, 32'd0);
        end else begin
          want = pending_circuits.pop_front();
          if (rsp_if.circuit_value !== want.value)
            report_mismatch("circuit_value", rsp_if.circuit_value, want.value);
          if (rsp_if.status !== want.status)
            report_mismatch("status", {31'd0, rsp_if.status}, {31'd0, want.status});
        end
        circuits_seen++;
      end
      if (stall > 0) begin
        stall--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
        if (!steady && $urandom_range(0, 99) < 12) stall = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed table, then random phases, one length each.
  // ---------------------------------------------------------------------------
  initial begin
    req_item_t      it;
    logic [31:0]    shots;
    logic [LEN_W-1:0] len;
    int unsigned    sent;
    int unsigned    n;
    int unsigned    r;
    int unsigned    lim;
    bit             by_close;

    rst_ni                 = 1'b0;
    cfg_we_i               = 1'b0;
    cfg_wdata_i            = '0;
    req_if.valid           = 1'b0;
    req_if.action          = ACT_WRITE;
    req_if.gradient_slot   = '0;
    req_if.gradient_value  = '0;
    req_if.outcome_index   = '0;
    req_if.outcome_count   = '0;
    req_if.shot_total      = '0;
    req_if.last_in_circuit = 1'b0;
    acc_sum                = '0;
    acc_range_err          = 1'b0;
    len_reg                = LEN_RESET;
    mismatches             = 0;
    circuits_seen          = 0;
    steady                 = 1'b0;
    for (int i = 0; i < GRAD_DEPTH; i++) begin
      grad_mem[i]     = '0;
      slot_written[i] = 1'b0;
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part runs at the reset length
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (DIRECTED[i].req.action == ACT_WRITE) note_written(DIRECTED[i].req.slot);
      send_req(DIRECTED[i].req, DIRECTED[i].typed, DIRECTED[i].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      case (p)
        0:          len = 11'd1024;
        1:          len = 11'd2047;  // above the store depth, clamps to it
        2:          len = 11'd0;     // every index is a range error
        3:          len = 11'd1;
        PHASES - 1: len = 11'd1024;
        default:    len = LEN_W'($urandom_range(1, 1024));
      endcase
      write_length(len);
      steady = ($urandom_range(0, 3) == 0);
      lim    = active_length();
      sent   = 0;

      // load some slots the circuits of this phase can read
      if (lim > 0) begin
        repeat ($urandom_range(4, 16)) begin
          it        = rand_item();
          it.action = ACT_WRITE;
          it.slot   = 10'($urandom_range(0, lim - 1));
          it.value  = pick_value();
          note_written(it.slot);
          send_req(it);
          sent++;
        end
      end

      while (sent < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          // well-formed circuit, closed by its last entry or by an empty close
          n        = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
          by_close = ($urandom_range(0, 4) == 0);
          shots    = pick_shots();
          for (int e = 0; e < n; e++) begin
            it        = rand_item();
            it.action = ACT_ACCUM;
            it.index  = ($urandom_range(0, 99) < 4) ? wild_index() : grad_index();
            it.count  = pick_count();
            it.last   = !by_close && (e == n - 1);
            if (it.last) it.shots = shots;
            send_req(it);
            sent++;
          end
          if (by_close) begin
            it        = rand_item();
            it.action = ACT_CLOSE;
            it.shots  = shots;
            send_req(it);
            sent++;
          end
        end else if (r < 80) begin
          it        = rand_item();
          it.action = ACT_CLOSE;
          it.shots  = pick_shots();
          send_req(it);
          sent++;
        end else if (r < 88) begin
          // store write in the middle of the stream, anywhere in the store
          it        = rand_item();
          it.action = ACT_WRITE;
          it.value  = pick_value();
          note_written(it.slot);
          send_req(it);
          sent++;
        end else if (r < 93) begin
          it        = rand_item();
          it.action = ACT_UNUSED;
          send_req(it);
        end else begin
          // broken entry: raw index if out of range, random last flag
          it        = rand_item();
          it.action = ACT_ACCUM;
          if (it.index < lim) it.index = grad_index();
          send_req(it);
          sent++;
        end
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #(WATCHDOG_CYCLES * CLK_PERIOD);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
